@@ design/assert_macros.svh @@
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_CLK(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ design/mtrb_pkg.sv @@
// Types and constants of the masked two record time blend unit.
package mtrb_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned WeightW = 17;
  localparam int unsigned FlagsW  = 5;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [WeightW-1:0] OneQ16 = 17'h10000;

  localparam int unsigned FlagMin    = 0;
  localparam int unsigned FlagMax    = 1;
  localparam int unsigned FlagFill   = 2;
  localparam int unsigned FlagMiss   = 3;
  localparam int unsigned FlagSingle = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WEIGHT   = 3'd0,
    CFG_MINIMUM  = 3'd1,
    CFG_MAXIMUM  = 3'd2,
    CFG_FILL     = 3'd3,
    CFG_MISSING  = 3'd4,
    CFG_MISS_OUT = 3'd5,
    CFG_FLAGS    = 3'd6
  } cfg_index_e;

  typedef struct packed {
    logic                      min_en;
    logic                      max_en;
    logic                      fill_en;
    logic                      miss_en;
    logic signed [SampleW-1:0] minimum;
    logic signed [SampleW-1:0] maximum;
    logic signed [SampleW-1:0] fill;
    logic signed [SampleW-1:0] missing;
  } chk_cfg_t;

endpackage

@@ design/mtrb_check.sv @@
// Range and marker check of one sample.
module mtrb_check import mtrb_pkg::*; (
  input  chk_cfg_t                  cfg_i,
  input  logic signed [SampleW-1:0] sample_i,
  output logic                      ok_o
);

  logic below_min;
  logic above_max;
  logic is_fill;
  logic is_missing;

  assign below_min  = cfg_i.min_en  && (sample_i < cfg_i.minimum);
  assign above_max  = cfg_i.max_en  && (sample_i > cfg_i.maximum);
  assign is_fill    = cfg_i.fill_en && (sample_i == cfg_i.fill);
  assign is_missing = cfg_i.miss_en && (sample_i == cfg_i.missing);

  assign ok_o = !(below_min || above_max || is_fill || is_missing);

endmodule

@@ design/masked_two_record_time_blend_unit.sv @@
// Top level of the masked two record time blend unit.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_stall_o    first_sample, second_sample, last_point
//   out      output     out_valid_o/out_stall_i  blended_value, point_valid, last_point_out
//   cfg      input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// One point per cycle while the output is not stalled; each point passes these steps in order:
// check and difference, 33x18 multiply, add with saturation and selection.
// Reset clears the configuration registers and stage valids; writes are always taken.
// A stall on the output holds the output register and fills the stages behind it.
module masked_two_record_time_blend_unit import mtrb_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [SampleW-1:0] first_sample_i,
  input  logic signed [SampleW-1:0] second_sample_i,
  input  logic                      last_point_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SampleW-1:0] blended_value_o,
  output logic                      point_valid_o,
  output logic                      last_point_out_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [SampleW-1:0]        cfg_data_i
);

  `include "assert_macros.svh"

  logic [WeightW-1:0]        weight_q;
  logic signed [SampleW-1:0] minimum_q;
  logic signed [SampleW-1:0] maximum_q;
  logic signed [SampleW-1:0] fill_q;
  logic signed [SampleW-1:0] missing_q;
  logic signed [SampleW-1:0] miss_out_q;
  logic [FlagsW-1:0]         flags_q;

  chk_cfg_t           chk_cfg;
  logic               ok_first;
  logic               ok_second;
  logic               single;
  logic [WeightW-1:0] weight_sat;

  logic                      s1_valid_q;
  logic signed [SampleW-1:0] s1_a_q;
  logic signed [SampleW:0]   s1_diff_q;
  logic [WeightW-1:0]        s1_weight_q;
  logic                      s1_ok_q;
  logic                      s1_single_q;
  logic                      s1_last_q;

  logic                          s2_valid_q;
  logic signed [SampleW-1:0]     s2_a_q;
  logic signed [SampleW+WeightW:0] s2_prod_q;
  logic                          s2_ok_q;
  logic                          s2_single_q;
  logic                          s2_last_q;

  logic                      out_valid_q;
  logic signed [SampleW-1:0] out_value_q;
  logic                      out_ok_q;
  logic                      out_last_q;

  logic                      s1_ready;
  logic                      s2_ready;
  logic                      s3_ready;
  logic signed [SampleW+2:0] s2_sum;
  logic                      s2_sat_hi;
  logic                      s2_sat_lo;
  logic signed [SampleW-1:0] s2_blend;
  logic signed [SampleW-1:0] out_value_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q   <= '0;
      minimum_q  <= '0;
      maximum_q  <= '0;
      fill_q     <= '0;
      missing_q  <= '0;
      miss_out_q <= '0;
      flags_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_WEIGHT:   weight_q   <= cfg_data_i[WeightW-1:0];
        CFG_MINIMUM:  minimum_q  <= cfg_data_i;
        CFG_MAXIMUM:  maximum_q  <= cfg_data_i;
        CFG_FILL:     fill_q     <= cfg_data_i;
        CFG_MISSING:  missing_q  <= cfg_data_i;
        CFG_MISS_OUT: miss_out_q <= cfg_data_i;
        CFG_FLAGS:    flags_q    <= cfg_data_i[FlagsW-1:0];
        default: ;
      endcase
    end
  end

  assign chk_cfg.min_en  = flags_q[FlagMin];
  assign chk_cfg.max_en  = flags_q[FlagMax];
  assign chk_cfg.fill_en = flags_q[FlagFill];
  assign chk_cfg.miss_en = flags_q[FlagMiss];
  assign chk_cfg.minimum = minimum_q;
  assign chk_cfg.maximum = maximum_q;
  assign chk_cfg.fill    = fill_q;
  assign chk_cfg.missing = missing_q;

  assign single     = flags_q[FlagSingle];
  assign weight_sat = weight_q[WeightW-1] ? OneQ16 : weight_q;

  mtrb_check u_check_first (
    .cfg_i    (chk_cfg),
    .sample_i (first_sample_i),
    .ok_o     (ok_first)
  );

  mtrb_check u_check_second (
    .cfg_i    (chk_cfg),
    .sample_i (second_sample_i),
    .ok_o     (ok_second)
  );

  assign s3_ready   = !out_valid_q || !out_stall_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;

  // Stage 1: check samples, form the difference.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_a_q      <= first_sample_i;
      s1_diff_q   <= {second_sample_i[SampleW-1], second_sample_i}
                   - {first_sample_i[SampleW-1], first_sample_i};
      s1_weight_q <= weight_sat;
      s1_ok_q     <= ok_first && (single || ok_second);
      s1_single_q <= single;
      s1_last_q   <= last_point_i;
    end
  end

  // Stage 2: scale the difference by the weight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_a_q      <= s1_a_q;
      s2_prod_q   <= s1_diff_q * $signed({1'b0, s1_weight_q});
      s2_ok_q     <= s1_ok_q;
      s2_single_q <= s1_single_q;
      s2_last_q   <= s1_last_q;
    end
  end

  // Stage 3: add back the first sample, saturate, select.
  assign s2_sum    = {{3{s2_a_q[SampleW-1]}}, s2_a_q}
                   + {s2_prod_q[SampleW+WeightW], s2_prod_q[SampleW+WeightW:16]};
  assign s2_sat_hi = !s2_sum[SampleW+2] && (s2_sum[SampleW+1:SampleW-1] != 3'b000);
  assign s2_sat_lo = s2_sum[SampleW+2] && (s2_sum[SampleW+1:SampleW-1] != 3'b111);

  always_comb begin
    if (s2_sat_hi) begin
      s2_blend = {1'b0, {(SampleW-1){1'b1}}};
    end else if (s2_sat_lo) begin
      s2_blend = {1'b1, {(SampleW-1){1'b0}}};
    end else begin
      s2_blend = s2_sum[SampleW-1:0];
    end
  end

  always_comb begin
    if (!s2_ok_q) begin
      out_value_d = miss_out_q;
    end else if (s2_single_q) begin
      out_value_d = s2_a_q;
    end else begin
      out_value_d = s2_blend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s3_ready) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      out_value_q <= out_value_d;
      out_ok_q    <= s2_ok_q;
      out_last_q  <= s2_last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign blended_value_o  = out_value_q;
  assign point_valid_o    = out_ok_q;
  assign last_point_out_o = out_last_q;

  `ASSERT_CLK(a_invalid_gives_missing,
    (out_valid_o && !point_valid_o) |-> (blended_value_o == miss_out_q))
  `ASSERT_NEVER(a_stall_only_when_full,
    in_stall_o && !(s1_valid_q && s2_valid_q && out_valid_q && out_stall_i))
  `ASSERT_CLK(a_single_passes_first,
    (s2_valid_q && s2_ok_q && s2_single_q) |-> (out_value_d == s2_a_q))

endmodule
